// ===== rtl/rpn_pkg.sv =====
// shared constants, codes and types for the postfix stack evaluator
package rpn_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);

  // beat field widths
  localparam int CMD_W       = 3;
  localparam int OPND_W      = 32;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_OUT_W = 5;
  localparam int M_TDATA_W   = 40;
  localparam int M_PAD_W     = M_TDATA_W - VALUE_W - DEPTH_OUT_W;

  // token codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_YIELD = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_REFILL,
    S_OUT
  } rpn_state_e;

endpackage

// ===== rtl/rpn_div.sv =====
// bit-serial signed divider, truncating, one quotient bit per cycle
module rpn_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rpn_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [rpn_pkg::DATA_WIDTH-1:0] divisor_i,
  output logic                           done_o,
  output logic [rpn_pkg::DATA_WIDTH-1:0] quotient_o
);

  localparam int W = rpn_pkg::DATA_WIDTH;

  logic                           busy_q, done_q, neg_q;
  logic [rpn_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [W-1:0]                   rem_q, quo_q, dvs_q;
  logic [W-1:0]                   mag_a, mag_b;
  logic [W:0]                     shifted, trial;

  // magnitudes; the most negative value maps onto its own unsigned pattern
  assign mag_a = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
  assign mag_b = divisor_i[W-1]  ? (~divisor_i + W'(1))  : divisor_i;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rpn_pkg::DIV_CNT_W'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - rpn_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      quo_q <= mag_a;
      dvs_q <= mag_b;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

// ===== rtl/rpn_stack_evaluator_unit.sv =====
// top level of the postfix stack evaluator: stack memory, token sequencer, result register
//
// channel  dir  beat fields (low bit first)
// -------  ---  ----------------------------------------------------------
// s_axis   in   tuser: cmd[2:0]; tdata: operand[31:0]
// m_axis   out  tuser: status[1:0]; tdata: top_value[31:0], stack_depth[36:32], pad
//
// one token at a time: push and yield pass through decode to the result register (yield
// with a refill of the top entry also through refill), add, subtract and multiply through
// decode and execute, divide also through the bit-serial divider, one quotient bit per cycle
// the next token is accepted while a finished result still waits in the output register
// reset empties the stack; the stack memory itself is never cleared, only entries
// below the depth count are ever read
// a stalled result sink holds the sequencer in its output state, nothing is dropped
module rpn_stack_evaluator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // token in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rpn_pkg::OPND_W-1:0]    s_axis_tdata_i,  // [31:0] operand
  input  logic [rpn_pkg::CMD_W-1:0]     s_axis_tuser_i,  // [2:0] cmd
  // result out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rpn_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // [31:0] top_value, [36:32] stack_depth
  output logic [rpn_pkg::STATUS_W-1:0]  m_axis_tuser_o   // [1:0] status
);

  localparam int W = rpn_pkg::DATA_WIDTH;

  // sequencer state
  rpn_pkg::rpn_state_e state_q, state_d;

  // token being worked on
  logic [rpn_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [W-1:0]              opnd_q, opnd_d;

  // stack control: depth count and a cached copy of the top entry
  logic [rpn_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]              top_q, top_d;

  // result under construction
  logic [W-1:0]              pop_q, pop_d;
  logic                      yld_q, yld_d;
  rpn_pkg::status_e          st_q, st_d;

  // result register feeding the master side
  logic                         m_valid_q;
  logic [rpn_pkg::VALUE_W-1:0]  out_val_q;
  logic [rpn_pkg::DEPTH_OUT_W-1:0] out_depth_q;
  rpn_pkg::status_e             out_st_q;
  logic                         out_load, out_free;
  logic [W-1:0]                 res_val;

  // stack memory, one write and one registered read port
  logic [W-1:0]              stack_mem_q [rpn_pkg::STACK_DEPTH];
  logic                      mem_we, mem_re;
  logic [rpn_pkg::IDX_W-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]              mem_wdata, rd_data_q;

  // arithmetic
  logic [W-1:0] alu_a, alu_b, alu_sum, alu_diff, alu_prod;
  logic         div_start, div_done;
  logic [W-1:0] div_quo;

  logic s_fire;
  logic cnt_full, cnt_lt2, cnt_zero;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign cnt_full = cnt_q >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);
  assign cnt_lt2  = cnt_q < rpn_pkg::CNT_W'(2);
  assign cnt_zero = cnt_q == '0;

  // left operand comes from memory, right operand from the top cache
  assign alu_a    = rd_data_q;
  assign alu_b    = top_q;
  assign alu_sum  = alu_a + alu_b;
  assign alu_diff = alu_a - alu_b;
  assign alu_prod = alu_a * alu_b;

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (alu_a),
    .divisor_i  (alu_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::S_IDLE: begin
        if (s_fire) state_d = rpn_pkg::S_DECODE;
      end
      rpn_pkg::S_DECODE: begin
        case (cmd_q)
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
            state_d = cnt_lt2 ? rpn_pkg::S_OUT : rpn_pkg::S_EXEC;
          end
          rpn_pkg::CMD_YIELD: begin
            state_d = cnt_lt2 ? rpn_pkg::S_OUT : rpn_pkg::S_REFILL;
          end
          default: state_d = rpn_pkg::S_OUT;
        endcase
      end
      rpn_pkg::S_EXEC: begin
        if (cmd_q == rpn_pkg::CMD_DIV && alu_b != '0) state_d = rpn_pkg::S_DIV;
        else state_d = rpn_pkg::S_OUT;
      end
      rpn_pkg::S_DIV: begin
        if (div_done) state_d = rpn_pkg::S_OUT;
      end
      rpn_pkg::S_REFILL: state_d = rpn_pkg::S_OUT;
      rpn_pkg::S_OUT: begin
        if (out_free) state_d = rpn_pkg::S_IDLE;
      end
      default: state_d = rpn_pkg::S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_d     = cmd_q;
    opnd_d    = opnd_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    pop_d     = pop_q;
    yld_d     = yld_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = rpn_pkg::IDX_W'(cnt_q - rpn_pkg::CNT_W'(2));
    mem_raddr = rpn_pkg::IDX_W'(cnt_q - rpn_pkg::CNT_W'(2));
    mem_wdata = alu_sum;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      rpn_pkg::S_IDLE: begin
        // ready is always high here, so a valid beat is taken
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_d  = s_axis_tuser_i;
          opnd_d = W'(signed'(s_axis_tdata_i));
          st_d   = rpn_pkg::ST_OK;
          yld_d  = 1'b0;
        end
      end
      rpn_pkg::S_DECODE: begin
        case (cmd_q)
          rpn_pkg::CMD_PUSH: begin
            if (cnt_full) begin
              st_d = rpn_pkg::ST_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = rpn_pkg::IDX_W'(cnt_q);
              mem_wdata = opnd_q;
              top_d     = opnd_q;
              cnt_d     = cnt_q + rpn_pkg::CNT_W'(1);
            end
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
            // fetch the left operand, the right one sits in the top cache
            if (cnt_lt2) st_d = rpn_pkg::ST_UNDER;
            else mem_re = 1'b1;
          end
          rpn_pkg::CMD_YIELD: begin
            if (cnt_zero) begin
              st_d = rpn_pkg::ST_UNDER;
            end else begin
              pop_d  = top_q;
              yld_d  = 1'b1;
              cnt_d  = cnt_q - rpn_pkg::CNT_W'(1);
              // entry below becomes the new top
              mem_re = !cnt_lt2;
            end
          end
          default: ;
        endcase
      end
      rpn_pkg::S_EXEC: begin
        case (cmd_q)
          rpn_pkg::CMD_DIV: begin
            if (alu_b == '0) st_d = rpn_pkg::ST_DIVZ;
            else div_start = 1'b1;
          end
          default: begin
            if (cmd_q == rpn_pkg::CMD_SUB) mem_wdata = alu_diff;
            else if (cmd_q == rpn_pkg::CMD_MUL) mem_wdata = alu_prod;
            else mem_wdata = alu_sum;
            mem_we = 1'b1;
            top_d  = mem_wdata;
            cnt_d  = cnt_q - rpn_pkg::CNT_W'(1);
          end
        endcase
      end
      rpn_pkg::S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = div_quo;
          top_d     = div_quo;
          cnt_d     = cnt_q - rpn_pkg::CNT_W'(1);
        end
      end
      rpn_pkg::S_REFILL: top_d = rd_data_q;
      rpn_pkg::S_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // popped value on a yield, else the top or zero on an empty stack
  assign res_val = yld_q ? pop_q : (cnt_zero ? '0 : top_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rpn_pkg::S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    opnd_q <= opnd_d;
    top_q  <= top_d;
    pop_q  <= pop_d;
    yld_q  <= yld_d;
    st_q   <= st_d;
    if (out_load) begin
      out_val_q   <= rpn_pkg::VALUE_W'(signed'(res_val));
      out_depth_q <= rpn_pkg::DEPTH_OUT_W'(cnt_q);
      out_st_q    <= st_q;
    end
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= stack_mem_q[mem_raddr];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{rpn_pkg::M_PAD_W{1'b0}}, out_depth_q, out_val_q};
  assign m_axis_tuser_o  = out_st_q;

  // depth count never passes the stack size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack depth count beyond stack size");

  // divider is only started with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (alu_b != '0))
    else $error("divider started with zero divisor");

  // quotient arrives only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rpn_pkg::S_DIV))
    else $error("divider finished outside the divide state");

  // an idle cycle without a new token leaves the stack alone
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpn_pkg::S_IDLE && !s_fire) |=> $stable(cnt_q))
    else $error("stack depth changed while idle");

endmodule

// ===== tb/sv/rpn_result_checker.sv =====
// result checker for the postfix stack evaluator: mirrors the stack and scores every result beat
`timescale 1ns / 100ps

module rpn_result_checker
  import rpn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [OPND_W-1:0]      s_axis_tdata_i,   // [31:0] operand
  input  logic [CMD_W-1:0]       s_axis_tuser_i,   // [2:0] cmd
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [M_TDATA_W-1:0]   m_axis_tdata_i,   // [31:0] top_value, [36:32] stack_depth
  input  logic [STATUS_W-1:0]    m_axis_tuser_i,   // [1:0] status
  output int                     mismatch_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [VALUE_W-1:0]     value;
    status_e                status;
    logic [DEPTH_OUT_W-1:0] depth;
  } token_result_t;

  // private copy of the stack, advanced on every accepted token beat
  logic [DATA_WIDTH-1:0] stack_mirror [STACK_DEPTH];
  int unsigned           held;
  token_result_t         awaited_results [$];
  token_result_t         oldest;

  function automatic token_result_t evaluate_token(input logic [CMD_W-1:0]  cmd,
                                                   input logic [OPND_W-1:0] operand);
    token_result_t                r;
    logic signed [DATA_WIDTH-1:0] lhs;
    logic signed [DATA_WIDTH-1:0] rhs;
    logic [DATA_WIDTH-1:0]        outcome;
    logic [DATA_WIDTH-1:0]        popped;
    longint                       quotient;
    bit                           yielded;
    r.status = ST_OK;
    yielded  = 1'b0;
    popped   = '0;
    outcome  = '0;
    case (cmd)
      CMD_PUSH: begin
        if (held >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          stack_mirror[held] = operand;
          held++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (held < 2) begin
          r.status = ST_UNDER;
        end else begin
          rhs = stack_mirror[held-1];
          lhs = stack_mirror[held-2];
          if (cmd == CMD_DIV && rhs == 0) begin
            // both operands stay where they are
            r.status = ST_DIVZ;
          end else begin
            case (cmd)
              CMD_ADD: outcome = lhs + rhs;
              CMD_SUB: outcome = lhs - rhs;
              CMD_MUL: outcome = lhs * rhs;
              default: begin
                // 64-bit quotient, so most negative over minus one just wraps
                quotient = longint'(lhs) / longint'(rhs);
                outcome  = quotient[DATA_WIDTH-1:0];
              end
            endcase
            held--;
            stack_mirror[held-1] = outcome;
          end
        end
      end
      CMD_YIELD: begin
        if (held == 0) begin
          r.status = ST_UNDER;
        end else begin
          held--;
          popped  = stack_mirror[held];
          yielded = 1'b1;
        end
      end
      default: ;  // spare codes leave everything alone
    endcase
    if (yielded) r.value = popped;
    else if (held == 0) r.value = '0;
    else r.value = stack_mirror[held-1];
    r.depth = held[DEPTH_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held             = 0;
      mismatch_count_o = 0;
      awaited_results.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        awaited_results.push_back(evaluate_token(s_axis_tuser_i, s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no token outstanding: top_value %h status %0d",
                 m_axis_tdata_i[VALUE_W-1:0], m_axis_tuser_i);
          mismatch_count_o++;
        end else begin
          oldest = awaited_results.pop_front();
          if (m_axis_tdata_i[VALUE_W-1:0] !== oldest.value) begin
            $error("top_value: expected %h, got %h", oldest.value,
                   m_axis_tdata_i[VALUE_W-1:0]);
            mismatch_count_o++;
          end
          if (m_axis_tuser_i !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, m_axis_tuser_i);
            mismatch_count_o++;
          end
          if (m_axis_tdata_i[VALUE_W +: DEPTH_OUT_W] !== oldest.depth) begin
            $error("stack_depth: expected %0d, got %0d", oldest.depth,
                   m_axis_tdata_i[VALUE_W +: DEPTH_OUT_W]);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench top for the postfix stack evaluator: clock, reset, token stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import rpn_pkg::*;

  localparam int CLK_HALF_NS      = 4;
  localparam int RESET_CYCLES     = 10;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int TOKENS_PER_PHASE = 460;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 80;

  // codes the evaluator ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OPND_W-1:0]      s_axis_tdata;   // [31:0] operand
  logic [CMD_W-1:0]       s_axis_tuser;   // [2:0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;   // [31:0] top_value, [36:32] stack_depth, pad
  logic [STATUS_W-1:0]    m_axis_tuser;   // [1:0] status

  int mismatch_count;
  int pending;
  int tokens_sent;
  int cycle_count = 0;
  int src_idle_pct;
  int sink_idle_pct;
  bit sink_hold_req;

  always #CLK_HALF_NS clk_i = ~clk_i;

  rpn_stack_evaluator_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  rpn_result_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .s_axis_tuser_i   (s_axis_tuser),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tuser_i   (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // watchdog on the whole run
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result sink: random back-pressure, or one long hold-off when asked for
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [OPND_W-1:0] operand);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = operand;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tokens_sent++;
    @(negedge clk_i);
  endtask

  // operands lean towards the corners and small values so divides hit zero and signs mix
  function automatic logic [OPND_W-1:0] pick_operand();
    int near_zero;
    near_zero = int'($urandom_range(32)) - 16;
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return '1;
      4, 5:    return near_zero;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_operator();
    case ($urandom_range(3))
      0:       return CMD_ADD;
      1:       return CMD_SUB;
      2:       return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  // well-formed postfix expression with random operands, closed by a yield
  task automatic run_expression();
    int live;
    int pushed;
    int operand_total;
    live          = 0;
    pushed        = 0;
    operand_total = $urandom_range(2, 8);
    while (pushed < operand_total || live > 1) begin
      if (live < 2 || (pushed < operand_total && $urandom_range(1) == 1)) begin
        send_token(CMD_PUSH, pick_operand());
        pushed++;
        live++;
      end else begin
        send_token(pick_operator(), $urandom);
        live--;
      end
    end
    send_token(CMD_YIELD, $urandom);
  endtask

  task automatic run_random_phase(input int token_quota);
    int phase_end;
    phase_end = tokens_sent + token_quota;
    while (tokens_sent < phase_end) begin
      case ($urandom_range(19))
        12, 13: begin
          // push past full to hit overflow
          repeat (STACK_DEPTH + $urandom_range(1, 3)) send_token(CMD_PUSH, pick_operand());
        end
        14, 15: begin
          // drain with yields, often running dry
          repeat ($urandom_range(1, STACK_DEPTH + 2)) send_token(CMD_YIELD, $urandom);
        end
        16, 17, 18, 19: begin
          // noise: any code, any operand
          repeat ($urandom_range(1, 6)) send_token(CMD_W'($urandom_range(7)), $urandom);
        end
        default: run_expression();
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PUSH;
    tokens_sent   = 0;
    sink_hold_req = 1'b0;
    src_idle_pct  = 33;
    sink_idle_pct = 75;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners
    send_token(CMD_YIELD, 32'h1234_5678);      // yield on empty stack
    send_token(CMD_ADD, '0);                   // operator on empty stack
    send_token(CMD_PUSH, 32'h7fff_ffff);
    send_token(CMD_SUB, '0);                   // operator with one entry
    send_token(CMD_PUSH, 32'h0000_0001);
    send_token(CMD_ADD, '1);                   // wraps to most negative
    send_token(CMD_PUSH, 32'hffff_ffff);
    send_token(CMD_DIV, '0);                   // most negative over minus one
    send_token(CMD_PUSH, '0);
    send_token(CMD_DIV, '0);                   // divide by zero keeps both
    send_token(CMD_SUB, '0);
    send_token(CMD_PUSH, 32'hffff_fff9);       // -7
    send_token(CMD_PUSH, 32'h0000_0002);
    send_token(CMD_DIV, '0);                   // truncates towards zero
    send_token(CMD_PUSH, 32'h8000_0000);
    send_token(CMD_MUL, '0);
    send_token(CMD_SPARE_6, 32'hffff_ffff);
    send_token(CMD_SPARE_7, 32'h5a5a_a5a5);
    send_token(CMD_YIELD, '0);
    send_token(CMD_YIELD, '0);
    send_token(CMD_YIELD, '0);

    run_random_phase(TOKENS_PER_PHASE);

    src_idle_pct  = 75;
    sink_idle_pct = 33;
    run_random_phase(TOKENS_PER_PHASE);

    // full speed, with one long sink hold-off so the block backs up onto its input
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold_req = 1'b1;
    run_random_phase(TOKENS_PER_PHASE);
    s_axis_tvalid = 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
